FILE: src/mav_pkg.sv
// Shared constants and types for the moving average window block.
package mav_pkg;

    localparam int DEF_MAX_WINDOW   = 64;
    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam int SUM_W = 22;
    localparam int AVG_W = 16;
    localparam int LEN_W = 7;

    localparam logic [LEN_W-1:0] RESET_LENGTH = LEN_W'(8);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV
    } t_state;

endpackage

FILE: src/mav_if.sv
// Valid/ready channel interfaces for samples, results and the length register.
interface mav_sample_if #(
    parameter int SAMPLE_WIDTH = mav_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface mav_result_if;
    logic                             valid;
    logic                             ready;
    logic                             window_full;
    logic signed [mav_pkg::SUM_W-1:0] window_sum;
    logic signed [mav_pkg::AVG_W-1:0] average;

    modport source (output valid, output window_full, output window_sum, output average,
                    input ready);
    modport sink (input valid, input window_full, input window_sum, input average,
                  output ready);
endinterface

interface mav_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [mav_pkg::LEN_W-1:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink (input valid, input window_length, output ready);
endinterface

FILE: src/mav_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mav_ram #(
    parameter int WIDTH = mav_pkg::DEF_SAMPLE_WIDTH,
    parameter int DEPTH = mav_pkg::DEF_MAX_WINDOW
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/mav_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module mav_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [mav_pkg::SUM_W-1:0] i_dividend,
    input  logic [mav_pkg::LEN_W-1:0]        i_divisor,
    output logic                             o_done,
    output logic signed [mav_pkg::SUM_W-1:0] o_quotient
);

    localparam int SUM_W = mav_pkg::SUM_W;
    localparam int LEN_W = mav_pkg::LEN_W;
    localparam int CNT_W = $clog2(SUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [LEN_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    logic [LEN_W-1:0] r_div;
    logic             r_neg;
    logic [SUM_W-1:0] r_result;

    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             ge;
    logic [LEN_W-1:0] n_rem;
    logic [SUM_W-1:0] n_quo;

    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        n_quo = {r_quo[SUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_quo <= i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            if (r_cnt == CNT_LAST) begin
                r_result <= r_neg ? (~n_quo + SUM_W'(1)) : n_quo;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_result;

endmodule

FILE: src/moving_average_window.sv
// Top level of the boxcar moving average over a configurable window of samples.
//
// Samples arrive as words on i_sample and each one yields exactly one result word on
// o_result carrying the full flag, the running window sum and the average, which is the
// sum divided by the window length and truncated toward zero. All channels move a word
// at a rising edge where valid and ready are both high.
// The window length is written on i_cfg while the block is idle; every write restarts
// the window with an empty sum. Lengths of zero count as one and lengths above the
// store depth count as the depth.
// A sample is only taken while the block is idle, so the next sample is taken after the
// result of the last one is registered. For each sample the ring store entry it replaces
// is read and the sum updated, then the divider produces one quotient bit per cycle
// over the 22-bit sum.
// The result waits in an output register while the receiver stalls, and a new sample
// is already accepted behind it; a second result waits in the divider until the
// output register frees.
// Reset restores a window length of 8, an empty window and a zero write position.
// The sample store itself is not cleared, since only written entries are ever read.
module moving_average_window #(
    parameter int MAX_WINDOW   = mav_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_WIDTH = mav_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mav_sample_if.sink   i_sample,
    mav_cfg_if.sink      i_cfg,
    mav_result_if.source o_result
);

    localparam int SUM_W  = mav_pkg::SUM_W;
    localparam int AVG_W  = mav_pkg::AVG_W;
    localparam int LEN_W  = mav_pkg::LEN_W;
    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int PTR_W  = ADDR_W + 1;
    localparam int LEN_MAX_VAL = (MAX_WINDOW > (2**LEN_W - 1)) ? (2**LEN_W - 1) : MAX_WINDOW;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(LEN_MAX_VAL);

    mav_pkg::t_state r_state;
    mav_pkg::t_state n_state;

    logic [ADDR_W-1:0]              r_wp;
    logic [ADDR_W-1:0]              n_wp;
    logic signed [SUM_W-1:0]        r_sum;
    logic signed [SUM_W-1:0]        n_sum;
    logic                           r_full;
    logic                           n_full;
    logic [LEN_W-1:0]               r_len;
    logic [LEN_W-1:0]               n_len;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           r_out_full;
    logic signed [SUM_W-1:0]        r_out_sum;
    logic signed [AVG_W-1:0]        r_out_avg;

    logic                           sample_fire;
    logic                           cfg_fire;
    logic                           div_start;
    logic                           div_done;
    logic signed [SUM_W-1:0]        div_quotient;
    logic                           load_out;
    logic                           ram_we;
    logic [SAMPLE_WIDTH-1:0]        ram_rdata;
    logic signed [SAMPLE_WIDTH-1:0] old_sample;
    logic [LEN_W-1:0]               eff_len;
    logic [PTR_W-1:0]               wp_inc;

    assign sample_fire = i_sample.valid & i_sample.ready;
    assign cfg_fire    = i_cfg.valid & i_cfg.ready;
    assign old_sample  = ram_rdata;

    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = r_len;
        end
        wp_inc = {1'b0, r_wp} + PTR_W'(1);
    end

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_sum       = r_sum;
        n_full      = r_full;
        n_len       = r_len;
        div_start   = 1'b0;
        load_out    = 1'b0;
        ram_we      = 1'b0;
        unique case (r_state)
            mav_pkg::S_IDLE: begin
                if (sample_fire) begin
                    n_state = mav_pkg::S_UPDATE;
                end
            end
            mav_pkg::S_UPDATE: begin
                ram_we    = 1'b1;
                div_start = 1'b1;
                n_state   = mav_pkg::S_DIV;
                n_wp      = (wp_inc >= PTR_W'(eff_len)) ? '0 : wp_inc[ADDR_W-1:0];
                if (r_full) begin
                    n_sum = r_sum + SUM_W'(r_sample) - SUM_W'(old_sample);
                end else begin
                    n_sum  = r_sum + SUM_W'(r_sample);
                    n_full = (n_wp == '0);
                end
            end
            mav_pkg::S_DIV: begin
                if (div_done && (!r_out_valid || o_result.ready)) begin
                    load_out = 1'b1;
                    n_state  = mav_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mav_pkg::S_IDLE;
            end
        endcase
        if (cfg_fire) begin
            n_len  = i_cfg.window_length;
            n_wp   = '0;
            n_sum  = '0;
            n_full = 1'b0;
        end
        n_out_valid = load_out | (r_out_valid & ~o_result.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mav_pkg::S_IDLE;
            r_wp        <= '0;
            r_sum       <= '0;
            r_full      <= 1'b0;
            r_len       <= mav_pkg::RESET_LENGTH;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_sum       <= n_sum;
            r_full      <= n_full;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sample_fire) begin
            r_sample <= i_sample.sample;
        end
        if (load_out) begin
            r_out_full <= r_full;
            r_out_sum  <= r_sum;
            r_out_avg  <= AVG_W'(div_quotient);
        end
    end

    mav_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_sample),
        .i_raddr (r_wp),
        .o_rdata (ram_rdata)
    );

    mav_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (eff_len),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign i_sample.ready       = (r_state == mav_pkg::S_IDLE);
    assign i_cfg.ready          = (r_state == mav_pkg::S_IDLE);
    assign o_result.valid       = r_out_valid;
    assign o_result.window_full = r_out_full;
    assign o_result.window_sum  = r_out_sum;
    assign o_result.average     = r_out_avg;

endmodule
